FILE: rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared constants, types and the legacy reciprocal step table of the
// idle CPU round-robin picker.
// ----------------------------------------------------------------------------
package rrp_pkg;

	localparam int MASK_BITS_DEF = 64;
	localparam int IN_MASK_W     = 64;
	localparam int BASE_W        = 12;
	localparam int CPU_W         = 13;
	localparam int CTR_W         = 32;
	localparam int PHASE_W       = 16;
	localparam int GRP_W         = 8;
	localparam int GCNT_W        = 4;
	localparam int SUB_W         = 3;
	localparam int STEP_IDX_W    = 6;

	localparam logic [CTR_W-1:0] GOLDEN_MULT = 32'h9E37_79B9;

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_IDX_MODE = 1'b0;
	localparam logic MODE_RESET   = 1'b1;

	localparam logic [PHASE_W-1:0] RECIP_STEP [64] = '{
		16'h0000, 16'h8000, 16'h5556, 16'h4000, 16'h3334, 16'h2AAB, 16'h2493, 16'h2000,
		16'h1C72, 16'h199A, 16'h1746, 16'h1556, 16'h13B2, 16'h124A, 16'h1112, 16'h1000,
		16'h0F10, 16'h0E39, 16'h0D7A, 16'h0CCD, 16'h0C31, 16'h0BA3, 16'h0B22, 16'h0AAB,
		16'h0A3E, 16'h09D9, 16'h097C, 16'h0925, 16'h08D4, 16'h0889, 16'h0843, 16'h0800,
		16'h07C2, 16'h0788, 16'h0751, 16'h071D, 16'h06EC, 16'h06BD, 16'h0691, 16'h0667,
		16'h063F, 16'h0619, 16'h05F5, 16'h05D2, 16'h05B1, 16'h0591, 16'h0573, 16'h0556,
		16'h053A, 16'h051F, 16'h0506, 16'h04ED, 16'h04D5, 16'h04BE, 16'h04A8, 16'h0493,
		16'h047E, 16'h046A, 16'h0457, 16'h0445, 16'h0433, 16'h0422, 16'h0411, 16'h0400
	};

	typedef struct packed {
		logic vld;
		logic mode;
		logic empty;
	} rrp_ctl_t;

endpackage

FILE: rtl/core/rrp_cfg.sv
// ----------------------------------------------------------------------------
// rrp_cfg
// APB register block holding the pick mode register.
// ----------------------------------------------------------------------------
module rrp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rrp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rrp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rrp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic                            improved_mode
);
	import rrp_pkg::*;

	logic mode_q;
	logic wr_en;
	logic hit_mode;

	assign pready   = 1'b1;
	assign hit_mode = (paddr[APB_ADDR_W-1] == REG_IDX_MODE);
	assign wr_en    = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (wr_en && hit_mode) begin
			mode_q <= pwdata[0];
		end
	end

	assign prdata        = hit_mode ? {{(APB_DATA_W-1){1'b0}}, mode_q} : '0;
	assign improved_mode = mode_q;

endmodule

FILE: rtl/core/rrp_count.sv
// ----------------------------------------------------------------------------
// rrp_count
// Stage 1: per-byte and total set-bit counts, golden-ratio scramble of the
// rotation counter.
// ----------------------------------------------------------------------------
module rrp_count #(
	parameter int MASK_BITS = rrp_pkg::MASK_BITS_DEF,
	parameter int NUM_GRP   = (MASK_BITS + rrp_pkg::GRP_W - 1) / rrp_pkg::GRP_W,
	parameter int CNT_W     = $clog2(MASK_BITS + 1)
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_vld,
	input  logic                                         mode,
	input  logic [rrp_pkg::BASE_W-1:0]                   base_cpu,
	input  logic [MASK_BITS-1:0]                         mask,
	input  logic [rrp_pkg::CTR_W-1:0]                    rotation_counter,
	output rrp_pkg::rrp_ctl_t                            ctl_s1,
	output logic [rrp_pkg::BASE_W-1:0]                   base_s1,
	output logic [NUM_GRP*rrp_pkg::GRP_W-1:0]            gmask_s1,
	output logic [NUM_GRP-1:0][rrp_pkg::GCNT_W-1:0]      gcnt_s1,
	output logic [CNT_W-1:0]                             total_s1,
	output logic [rrp_pkg::CTR_W-1:0]                    scr_s1,
	output logic [rrp_pkg::PHASE_W-1:0]                  ctr_lo_s1
);
	import rrp_pkg::*;

	localparam int PAD_W = NUM_GRP * GRP_W;

	logic [PAD_W-1:0]                pad;
	logic [NUM_GRP-1:0][GCNT_W-1:0]  gcnt;
	logic [CNT_W-1:0]                total;
	logic [CTR_W-1:0]                scr;

	assign pad = PAD_W'(mask);
	assign scr = rotation_counter * GOLDEN_MULT;

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			gcnt[g] = '0;
			for (int b = 0; b < GRP_W; b++) begin
				gcnt[g] = gcnt[g] + GCNT_W'(pad[g*GRP_W+b]);
			end
		end
		total = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			total = total + CNT_W'(gcnt[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld   <= in_vld;
			ctl_s1.mode  <= mode;
			ctl_s1.empty <= (total == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			base_s1   <= base_cpu;
			gmask_s1  <= pad;
			gcnt_s1   <= gcnt;
			total_s1  <= total;
			scr_s1    <= scr;
			ctr_lo_s1 <= rotation_counter[PHASE_W-1:0];
		end
	end

endmodule

FILE: rtl/core/rrp_index.sv
// ----------------------------------------------------------------------------
// rrp_index
// Stages 2 and 3: map the scrambled counter or the legacy phase to the
// index of the set bit to take.
// ----------------------------------------------------------------------------
module rrp_index #(
	parameter int MASK_BITS = rrp_pkg::MASK_BITS_DEF,
	parameter int NUM_GRP   = (MASK_BITS + rrp_pkg::GRP_W - 1) / rrp_pkg::GRP_W,
	parameter int CNT_W     = $clog2(MASK_BITS + 1),
	parameter int PICK_W    = $clog2(MASK_BITS)
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  rrp_pkg::rrp_ctl_t                            ctl_s1,
	input  logic [rrp_pkg::BASE_W-1:0]                   base_s1,
	input  logic [NUM_GRP*rrp_pkg::GRP_W-1:0]            gmask_s1,
	input  logic [NUM_GRP-1:0][rrp_pkg::GCNT_W-1:0]      gcnt_s1,
	input  logic [CNT_W-1:0]                             total_s1,
	input  logic [rrp_pkg::CTR_W-1:0]                    scr_s1,
	input  logic [rrp_pkg::PHASE_W-1:0]                  ctr_lo_s1,
	output rrp_pkg::rrp_ctl_t                            ctl_s3,
	output logic [rrp_pkg::BASE_W-1:0]                   base_s3,
	output logic [NUM_GRP*rrp_pkg::GRP_W-1:0]            gmask_s3,
	output logic [NUM_GRP-1:0][rrp_pkg::GCNT_W-1:0]      gcnt_s3,
	output logic [PICK_W-1:0]                            pick_s3
);
	import rrp_pkg::*;

	localparam int PAD_W = NUM_GRP * GRP_W;
	localparam int PI_W  = CTR_W + CNT_W;
	localparam int PL_W  = PHASE_W + CNT_W;

	rrp_ctl_t                        ctl_s2;
	logic [BASE_W-1:0]               base_s2;
	logic [PAD_W-1:0]                gmask_s2;
	logic [NUM_GRP-1:0][GCNT_W-1:0]  gcnt_s2;
	logic [CNT_W-1:0]                total_s2;
	logic [PICK_W-1:0]               pick_imp_s2;
	logic [PHASE_W-1:0]              phase_s2;

	logic [PI_W-1:0]                 prod_imp;
	logic [CNT_W-1:0]                total_m1;
	logic [PHASE_W-1:0]              step;
	logic [2*PHASE_W-1:0]            prod_phase;
	logic [PICK_W-1:0]               pick_imp;
	logic [PL_W-1:0]                 prod_leg;
	logic [PICK_W-1:0]               pick_leg;

	// stage 2: range map and legacy phase
	assign prod_imp   = PI_W'(scr_s1) * PI_W'(total_s1);
	assign total_m1   = total_s1 - CNT_W'(1);
	assign step       = RECIP_STEP[STEP_IDX_W'(total_m1)];
	assign prod_phase = ctr_lo_s1 * step;

	always_comb begin
		if (total_s1 == CNT_W'(2)) begin
			pick_imp = PICK_W'(ctr_lo_s1[0]);
		end else if (total_s1 < CNT_W'(2)) begin
			pick_imp = '0;
		end else begin
			pick_imp = prod_imp[CTR_W +: PICK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			base_s2     <= base_s1;
			gmask_s2    <= gmask_s1;
			gcnt_s2     <= gcnt_s1;
			total_s2    <= total_s1;
			pick_imp_s2 <= pick_imp;
			phase_s2    <= prod_phase[PHASE_W-1:0];
		end
	end

	// stage 3: legacy index and mode select
	assign prod_leg = PL_W'(phase_s2) * PL_W'(total_s2);
	assign pick_leg = prod_leg[PHASE_W +: PICK_W];

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			base_s3  <= base_s2;
			gmask_s3 <= gmask_s2;
			gcnt_s3  <= gcnt_s2;
			pick_s3  <= ctl_s2.mode ? pick_imp_s2 : pick_leg;
		end
	end

endmodule

FILE: rtl/core/rrp_select.sv
// ----------------------------------------------------------------------------
// rrp_select
// Stages 4 and 5: locate the byte holding the chosen set bit, then the bit
// inside it, and form the CPU number.
// ----------------------------------------------------------------------------
module rrp_select #(
	parameter int MASK_BITS = rrp_pkg::MASK_BITS_DEF,
	parameter int NUM_GRP   = (MASK_BITS + rrp_pkg::GRP_W - 1) / rrp_pkg::GRP_W,
	parameter int CNT_W     = $clog2(MASK_BITS + 1),
	parameter int PICK_W    = $clog2(MASK_BITS)
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  rrp_pkg::rrp_ctl_t                            ctl_s3,
	input  logic [rrp_pkg::BASE_W-1:0]                   base_s3,
	input  logic [NUM_GRP*rrp_pkg::GRP_W-1:0]            gmask_s3,
	input  logic [NUM_GRP-1:0][rrp_pkg::GCNT_W-1:0]      gcnt_s3,
	input  logic [PICK_W-1:0]                            pick_s3,
	output logic                                         vld_s5,
	output logic [rrp_pkg::CPU_W-1:0]                    chosen_s5,
	output logic                                         empty_s5
);
	import rrp_pkg::*;

	localparam int GIDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int POS_W  = GIDX_W + SUB_W;

	rrp_ctl_t           ctl_s4;
	logic [BASE_W-1:0]  base_s4;
	logic [GRP_W-1:0]   byte_s4;
	logic [SUB_W-1:0]   res_s4;
	logic [GIDX_W-1:0]  grp_s4;

	logic [CNT_W-1:0]   acc;
	logic [CNT_W-1:0]   pick_ext;
	logic               g_found;
	logic [GIDX_W-1:0]  grp_sel;
	logic [GRP_W-1:0]   byte_sel;
	logic [SUB_W-1:0]   res_sel;

	logic [GCNT_W-1:0]  bcnt;
	logic               b_found;
	logic [SUB_W-1:0]   bit_sel;
	logic [POS_W-1:0]   pos;

	assign pick_ext = CNT_W'(pick_s3);

	// stage 4: walk byte counts to find the byte holding the pick
	always_comb begin
		acc      = '0;
		g_found  = 1'b0;
		grp_sel  = '0;
		byte_sel = '0;
		res_sel  = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (!g_found && (pick_ext < acc + CNT_W'(gcnt_s3[g]))) begin
				g_found  = 1'b1;
				grp_sel  = GIDX_W'(g);
				byte_sel = gmask_s3[g*GRP_W +: GRP_W];
				res_sel  = SUB_W'(pick_ext - acc);
			end
			acc = acc + CNT_W'(gcnt_s3[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			vld_s5 <= 1'b0;
		end else begin
			ctl_s4 <= ctl_s3;
			vld_s5 <= ctl_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.vld) begin
			base_s4 <= base_s3;
			byte_s4 <= byte_sel;
			res_s4  <= res_sel;
			grp_s4  <= grp_sel;
		end
	end

	// stage 5: nth set bit inside the byte
	always_comb begin
		bcnt    = '0;
		b_found = 1'b0;
		bit_sel = '0;
		for (int b = 0; b < GRP_W; b++) begin
			if (byte_s4[b]) begin
				if (!b_found && (bcnt == GCNT_W'(res_s4))) begin
					b_found = 1'b1;
					bit_sel = SUB_W'(b);
				end
				bcnt = bcnt + GCNT_W'(1);
			end
		end
	end

	assign pos = {grp_s4, bit_sel};

	always_ff @(posedge clk) begin
		if (ctl_s4.vld) begin
			empty_s5 <= ctl_s4.empty;
			if (ctl_s4.empty) begin
				chosen_s5 <= CPU_W'(base_s4);
			end else begin
				chosen_s5 <= CPU_W'(base_s4) + CPU_W'(pos);
			end
		end
	end

`ifndef SYNTH
	a_byte_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s4.vld && !ctl_s4.empty) |-> (byte_s4 != '0))
		else $error("selected byte holds no set bit");

	a_res_in_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s4.vld && !ctl_s4.empty) |-> ($countones(byte_s4) > int'(res_s4)))
		else $error("residual index beyond set bits of byte");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s4.vld && ctl_s4.empty) |-> (byte_s4 == '0 && res_s4 == '0 && grp_s4 == '0))
		else $error("empty mask produced a selection");
`endif

endmodule

FILE: rtl/core/idle_cpu_round_robin_pick.sv
// ----------------------------------------------------------------------------
// idle_cpu_round_robin_pick
// Picks one idle CPU from an idle mask, a base CPU number and a rotation
// counter, in scramble/range-map mode or legacy step-table mode.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high; busy never rises. Each
// request yields exactly one result, chosen_cpu and mask_empty, shown for one
// cycle with done high once it leaves the pipeline: one stage counts set bits
// and scrambles the counter, two map the counter to a bit index, two locate
// that set bit byte by byte and add the base. Results cannot be held off.
// Write improved_mode only with no request in flight.
// ----------------------------------------------------------------------------
module idle_cpu_round_robin_pick #(
	parameter int MASK_BITS = rrp_pkg::MASK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [rrp_pkg::BASE_W-1:0]     base_cpu,
	input  logic [rrp_pkg::IN_MASK_W-1:0]  idle_mask,
	input  logic [rrp_pkg::CTR_W-1:0]      rotation_counter,
	output logic                            done,
	output logic [rrp_pkg::CPU_W-1:0]      chosen_cpu,
	output logic                            mask_empty,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rrp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rrp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rrp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import rrp_pkg::*;

	localparam int NUM_GRP = (MASK_BITS + GRP_W - 1) / GRP_W;
	localparam int CNT_W   = $clog2(MASK_BITS + 1);
	localparam int PICK_W  = $clog2(MASK_BITS);
	localparam int PAD_W   = NUM_GRP * GRP_W;

	logic                            mode;
	logic                            in_vld;

	rrp_ctl_t                        ctl_s1;
	logic [BASE_W-1:0]               base_s1;
	logic [PAD_W-1:0]                gmask_s1;
	logic [NUM_GRP-1:0][GCNT_W-1:0]  gcnt_s1;
	logic [CNT_W-1:0]                total_s1;
	logic [CTR_W-1:0]                scr_s1;
	logic [PHASE_W-1:0]              ctr_lo_s1;

	rrp_ctl_t                        ctl_s3;
	logic [BASE_W-1:0]               base_s3;
	logic [PAD_W-1:0]                gmask_s3;
	logic [NUM_GRP-1:0][GCNT_W-1:0]  gcnt_s3;
	logic [PICK_W-1:0]               pick_s3;

	assign busy   = 1'b0;
	assign in_vld = start & ~busy;

	rrp_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.improved_mode (mode)
	);

	rrp_count #(
		.MASK_BITS (MASK_BITS),
		.NUM_GRP   (NUM_GRP),
		.CNT_W     (CNT_W)
	) u_count (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_vld           (in_vld),
		.mode             (mode),
		.base_cpu         (base_cpu),
		.mask             (idle_mask[MASK_BITS-1:0]),
		.rotation_counter (rotation_counter),
		.ctl_s1           (ctl_s1),
		.base_s1          (base_s1),
		.gmask_s1         (gmask_s1),
		.gcnt_s1          (gcnt_s1),
		.total_s1         (total_s1),
		.scr_s1           (scr_s1),
		.ctr_lo_s1        (ctr_lo_s1)
	);

	rrp_index #(
		.MASK_BITS (MASK_BITS),
		.NUM_GRP   (NUM_GRP),
		.CNT_W     (CNT_W),
		.PICK_W    (PICK_W)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.base_s1   (base_s1),
		.gmask_s1  (gmask_s1),
		.gcnt_s1   (gcnt_s1),
		.total_s1  (total_s1),
		.scr_s1    (scr_s1),
		.ctr_lo_s1 (ctr_lo_s1),
		.ctl_s3    (ctl_s3),
		.base_s3   (base_s3),
		.gmask_s3  (gmask_s3),
		.gcnt_s3   (gcnt_s3),
		.pick_s3   (pick_s3)
	);

	rrp_select #(
		.MASK_BITS (MASK_BITS),
		.NUM_GRP   (NUM_GRP),
		.CNT_W     (CNT_W),
		.PICK_W    (PICK_W)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.base_s3   (base_s3),
		.gmask_s3  (gmask_s3),
		.gcnt_s3   (gcnt_s3),
		.pick_s3   (pick_s3),
		.vld_s5    (done),
		.chosen_s5 (chosen_cpu),
		.empty_s5  (mask_empty)
	);

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result transfer missing five cycles after request");

	a_empty_base: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && idle_mask == '0) |->
		##5 (done && mask_empty && chosen_cpu == CPU_W'($past(base_cpu, 5))))
		else $error("empty mask did not return base");

	a_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !mask_empty) |->
		((chosen_cpu - CPU_W'($past(base_cpu, 5))) < CPU_W'(MASK_BITS)))
		else $error("chosen cpu outside mask window");
`endif

endmodule

FILE: dv/tb_idle_cpu_round_robin_pick.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_idle_cpu_round_robin_pick
// Self-checking bench for the idle CPU picker. Requests go in through the
// start/busy port and the mode register through the APB port. Each accepted
// request is scored against a local model of both pick modes (golden-ratio
// scramble with range map, and the legacy reciprocal step). Results are
// matched in order against the queue of predicted picks.
// ----------------------------------------------------------------------------
module tb_idle_cpu_round_robin_pick;
	import rrp_pkg::*;

	localparam int  STALL_LIMIT  = 1000;
	localparam int  DRAIN_CYCLES = 8;
	localparam logic MODE_IMPROVED = 1'b1;
	localparam logic MODE_LEGACY   = 1'b0;
	localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * REG_IDX_MODE);

	typedef struct packed {
		logic [CPU_W-1:0] cpu;
		logic             empty;
	} pick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [BASE_W-1:0]     base_cpu = '0;
	logic [IN_MASK_W-1:0]  idle_mask = '0;
	logic [CTR_W-1:0]      rotation_counter = '0;
	logic                  done;
	logic [CPU_W-1:0]      chosen_cpu;
	logic                  mask_empty;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pick_t pending_picks[$];
	logic  mode_q = MODE_RESET;
	int    errors = 0;
	int    stall_cycles = 0;
	int    picks_checked = 0;
	int    sent_improved = 0;
	int    sent_legacy = 0;
	int    sent_empty = 0;

	idle_cpu_round_robin_pick dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.base_cpu(base_cpu),
		.idle_mask(idle_mask),
		.rotation_counter(rotation_counter),
		.done(done),
		.chosen_cpu(chosen_cpu),
		.mask_empty(mask_empty),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned nth_set_pos(logic [IN_MASK_W-1:0] m, int unsigned n);
		int unsigned seen;
		seen = 0;
		for (int i = 0; i < IN_MASK_W; i++) begin
			if (m[i]) begin
				if (seen == n)
					return i;
				seen++;
			end
		end
		return 0;
	endfunction

	function automatic pick_t predict_pick(logic mode, logic [BASE_W-1:0] b,
		logic [IN_MASK_W-1:0] m, logic [CTR_W-1:0] c);
		pick_t        p;
		int unsigned  total;
		int unsigned  idx;
		int unsigned  pos;
		logic [31:0]  scr;
		logic [63:0]  wide;
		logic [31:0]  prod;
		logic [15:0]  phase;
		total = $countones(m);
		if (total == 0) begin
			p.cpu   = CPU_W'(b);
			p.empty = 1'b1;
			return p;
		end
		if (mode) begin
			if (total <= 2) begin
				idx = (total == 2 && c[0]) ? 1 : 0;
			end else begin
				scr  = c * GOLDEN_MULT;
				wide = 64'(scr) * 64'(total);
				idx  = wide[63:32];
			end
		end else begin
			prod  = c * 32'(RECIP_STEP[(total - 1) & 63]);
			phase = prod[15:0];
			prod  = 32'(phase) * 32'(total);
			idx   = prod >> 16;
		end
		pos     = nth_set_pos(m, idx);
		p.cpu   = CPU_W'(b) + CPU_W'(pos);
		p.empty = 1'b0;
		return p;
	endfunction

	// Score every result strobe against the oldest predicted pick.
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && done) begin
			if (pending_picks.size() == 0) begin
				$display("%0t: unexpected result cpu=%0d empty=%0b", $time, chosen_cpu,
					mask_empty);
				errors++;
			end else begin
				want = pending_picks.pop_front();
				picks_checked++;
				if (chosen_cpu !== want.cpu) begin
					$display("%0t: chosen_cpu expected %0d actual %0d", $time, want.cpu,
						chosen_cpu);
					errors++;
				end
				if (mask_empty !== want.empty) begin
					$display("%0t: mask_empty expected %0b actual %0b", $time, want.empty,
						mask_empty);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_pick(input logic [BASE_W-1:0] b, input logic [IN_MASK_W-1:0] m,
		input logic [CTR_W-1:0] c);
		start            <= 1'b1;
		base_cpu         <= b;
		idle_mask        <= m;
		rotation_counter <= c;
		do @(posedge clk); while (busy);
		pending_picks.push_back(predict_pick(mode_q, b, m, c));
		if (m == '0)
			sent_empty++;
		else if (mode_q)
			sent_improved++;
		else
			sent_legacy++;
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_picks();
		start <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] wdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= MODE_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== APB_DATA_W'(mode_q)) begin
			$display("%0t: improved_mode read expected %0h actual %0h", $time,
				APB_DATA_W'(mode_q), prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_mode(input logic m);
		drain_picks();
		apb_transfer(1'b1, APB_DATA_W'(m));
		mode_q = m;
		@(posedge clk);
		apb_transfer(1'b0, '0);
	endtask

	function automatic logic [IN_MASK_W-1:0] rand_mask();
		logic [IN_MASK_W-1:0] m;
		int unsigned          k;
		int unsigned          kind;
		m    = '0;
		kind = $urandom_range(0, 19);
		if (kind == 0)
			return '0;
		if (kind == 1)
			return '1;
		if (kind >= 12)
			return {$urandom, $urandom};
		k = (kind < 7) ? $urandom_range(1, 3) : $urandom_range(1, IN_MASK_W);
		while ($countones(m) < k)
			m[$urandom_range(0, IN_MASK_W - 1)] = 1'b1;
		return m;
	endfunction

	task automatic run_random(input int n, input bit with_idle);
		for (int i = 0; i < n; i++) begin
			if (with_idle && $urandom_range(0, 7) == 0)
				idle_for($urandom_range(1, 18));
			send_pick(BASE_W'($urandom), rand_mask(), $urandom);
		end
	endtask

	task automatic test_improved_directed();
		send_pick(12'hFFF, '0, 32'hFFFF_FFFF);
		send_pick(12'h000, '0, 32'h0);
		send_pick(12'hFFF, 64'h8000_0000_0000_0000, 32'h0);
		send_pick(12'h000, 64'h1, 32'hFFFF_FFFF);
		send_pick(12'd100, 64'h8000_0000_0000_0001, 32'h0);
		send_pick(12'd100, 64'h8000_0000_0000_0001, 32'h1);
		send_pick(12'd7, 64'h0000_0100_0000_0010, 32'hFFFF_FFFF);
		send_pick(12'h000, 64'h7, 32'h0);
		send_pick(12'h000, '1, 32'h0);
		send_pick(12'hFFF, '1, 32'hFFFF_FFFF);
		send_pick(12'h800, '1, 32'h1);
		send_pick(12'd5, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000);
		send_pick(12'd9, 64'h5555_5555_5555_5555, 32'h1234_5678);
	endtask

	task automatic test_legacy_directed();
		set_mode(MODE_LEGACY);
		send_pick(12'hFFF, '0, 32'h0);
		send_pick(12'hFFF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
		send_pick(12'h000, 64'h8000_0000_0000_0001, 32'h0);
		send_pick(12'h000, 64'h8000_0000_0000_0001, 32'h1);
		send_pick(12'h000, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF);
		send_pick(12'd33, 64'h0001_0000_0100_0001, 32'hFFFF_FFFF);
		send_pick(12'h000, '1, 32'h0);
		send_pick(12'hFFF, '1, 32'hFFFF_FFFF);
		send_pick(12'd1, '1, 32'h1);
		send_pick(12'd2, 64'h0F00_0000_0000_0010, 32'h0000_FFFF);
	endtask

	task automatic test_random_modes();
		set_mode(MODE_IMPROVED);
		run_random(300, 1'b1);
		set_mode(MODE_LEGACY);
		run_random(300, 1'b1);
		set_mode(MODE_IMPROVED);
		run_random(200, 1'b1);
	endtask

	task automatic test_drain_pause();
		set_mode(MODE_LEGACY);
		run_random(80, 1'b0);
		drain_picks();
		run_random(80, 1'b1);
	endtask

	task automatic test_back_to_back();
		set_mode(MODE_IMPROVED);
		run_random(100, 1'b0);
		set_mode(MODE_LEGACY);
		run_random(100, 1'b0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_transfer(1'b0, '0);
		test_improved_directed();
		test_legacy_directed();
		test_random_modes();
		test_drain_pause();
		test_back_to_back();
		drain_picks();
		$display("Checked %0d picks: %0d improved mode, %0d legacy mode, %0d empty masks.",
			picks_checked, sent_improved, sent_legacy, sent_empty);
		$display("Mode register written in both settings and read back after each write.");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
